>>> rtl/core/opdd_pkg.sv
// ----------------------------------------------------------------------------
// opdd_pkg
// Shared types, codes and helpers for the output port device detector.
// ----------------------------------------------------------------------------
package opdd_pkg;

    // Tick counter width; the counter saturates at its all-ones value.
    localparam int COUNT_BITS = 8;
    localparam int LIM_W      = 8;
    localparam int CMP_W      = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;
    localparam int MV_W       = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // link states
    localparam logic [2:0] ST_INIT        = 3'd0;
    localparam logic [2:0] ST_INIT_SETTLE = 3'd1;
    localparam logic [2:0] ST_NO_DEV      = 3'd2;
    localparam logic [2:0] ST_PIN6_SETTLE = 3'd3;
    localparam logic [2:0] ST_CONNECTED   = 3'd4;
    localparam logic [2:0] ST_PIN5_SETTLE = 3'd5;
    localparam logic [2:0] ST_DEV_FOUND   = 3'd6;
    localparam logic [2:0] ST_WAIT_DISC   = 3'd7;

    // device kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_NEW   = 3'd1;
    localparam logic [2:0] KIND_MINI  = 3'd2;
    localparam logic [2:0] KIND_TACHO = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // pin 5 drive modes
    localparam logic [1:0] P5_RELEASED = 2'd0;
    localparam logic [1:0] P5_HIGH     = 2'd1;
    localparam logic [1:0] P5_LOW      = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_HIGH = 3'd5;

    // voltage thresholds, mV
    localparam logic [MV_W-1:0] MV_IIC_HIGH   = 13'd3700;
    localparam logic [MV_W-1:0] MV_IIC_LOW    = 13'd2800;
    localparam logic [MV_W-1:0] MV_MINI_HIGH1 = 13'd2000;
    localparam logic [MV_W-1:0] MV_MINI_LOW1  = 13'd1600;
    localparam logic [MV_W-1:0] MV_LIGHT_HIGH = 13'd850;
    localparam logic [MV_W-1:0] MV_LIGHT_LOW  = 13'd650;
    localparam logic [MV_W-1:0] MV_MINI_HIGH2 = 13'd450;
    localparam logic [MV_W-1:0] MV_MINI_LOW2  = 13'd250;
    localparam logic [MV_W-1:0] MV_NEAR_GND   = 13'd100;
    localparam logic [MV_W-1:0] MV_SAME_TOL   = 13'd50;

    typedef struct packed {
        logic              auto_enable;
        logic [LIM_W-1:0]  settle_ticks;
        logic [LIM_W-1:0]  add_ticks;
        logic [LIM_W-1:0]  remove_ticks;
        logic [MV_W-1:0]   balance_low_mv;
        logic [MV_W-1:0]   balance_high_mv;
        logic              restart;
    } t_cfg;

    typedef struct packed {
        logic [2:0] kind;
        logic       to_found;
        logic       to_pin5;
    } t_class;

    typedef struct packed {
        logic [2:0] link_state;
        logic [2:0] detected_type;
        logic       pin6_drive_low;
        logic [1:0] pin5_drive;
        logic       float_pulse;
        logic       register_pulse;
        logic       unregister_pulse;
    } t_result;

    function automatic logic outside_balance(input logic [MV_W-1:0] mv,
                                             input logic [MV_W-1:0] lo,
                                             input logic [MV_W-1:0] hi);
        return (mv < lo) || (mv > hi);
    endfunction

    function automatic logic count_reached(input logic [COUNT_BITS-1:0] cnt,
                                           input logic [LIM_W-1:0] lim);
        return CMP_W'(cnt) >= CMP_W'(lim);
    endfunction

endpackage

>>> rtl/core/opdd_cfg.sv
// ----------------------------------------------------------------------------
// opdd_cfg
// Configuration registers and the auto-mode restart strobe.
// ----------------------------------------------------------------------------
module opdd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [opdd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [opdd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output opdd_pkg::t_cfg                    o_cfg
);
    import opdd_pkg::*;

    logic             r_auto;
    logic [LIM_W-1:0] r_settle;
    logic [LIM_W-1:0] r_add;
    logic [LIM_W-1:0] r_remove;
    logic [MV_W-1:0]  r_bal_lo;
    logic [MV_W-1:0]  r_bal_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto   <= 1'b1;
            r_settle <= LIM_W'(2);
            r_add    <= LIM_W'(35);
            r_remove <= LIM_W'(10);
            r_bal_lo <= MV_W'(2400);
            r_bal_hi <= MV_W'(2600);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AUTO:     r_auto   <= i_cfg_data[0];
                CFG_SETTLE:   r_settle <= i_cfg_data[LIM_W-1:0];
                CFG_ADD:      r_add    <= i_cfg_data[LIM_W-1:0];
                CFG_REMOVE:   r_remove <= i_cfg_data[LIM_W-1:0];
                CFG_BAL_LOW:  r_bal_lo <= i_cfg_data[MV_W-1:0];
                CFG_BAL_HIGH: r_bal_hi <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.auto_enable     = r_auto;
        o_cfg.settle_ticks    = r_settle;
        o_cfg.add_ticks       = r_add;
        o_cfg.remove_ticks    = r_remove;
        o_cfg.balance_low_mv  = r_bal_lo;
        o_cfg.balance_high_mv = r_bal_hi;
        // off -> on transition sends the sequence back to init
        o_cfg.restart = i_cfg_we && (i_cfg_idx == CFG_AUTO) && i_cfg_data[0] && !r_auto;
    end

endmodule

>>> rtl/core/opdd_classify.sv
// ----------------------------------------------------------------------------
// opdd_classify
// Classifies a connected device from the floating and pin-6-low readings.
// ----------------------------------------------------------------------------
module opdd_classify (
    input  logic [opdd_pkg::MV_W-1:0] i_float_mv,
    input  logic [opdd_pkg::MV_W-1:0] i_low_mv,
    input  logic                      i_pin6_flag,
    input  logic [opdd_pkg::MV_W-1:0] i_bal_lo,
    input  logic [opdd_pkg::MV_W-1:0] i_bal_hi,
    output opdd_pkg::t_class          o_class
);
    import opdd_pkg::*;

    logic [MV_W-1:0] w_diff;
    logic            w_mismatch;
    logic            w_bad_level;

    always_comb begin
        w_diff      = (i_float_mv >= i_low_mv) ? (i_float_mv - i_low_mv)
                                               : (i_low_mv - i_float_mv);
        w_mismatch  = w_diff >= MV_SAME_TOL;
        w_bad_level = (i_float_mv < MV_NEAR_GND)
                   || (i_float_mv >= MV_LIGHT_LOW && i_float_mv <= MV_LIGHT_HIGH)
                   || (i_float_mv >= MV_IIC_LOW && i_float_mv <= MV_IIC_HIGH);

        o_class.kind     = KIND_ERR;
        o_class.to_found = 1'b0;
        o_class.to_pin5  = 1'b0;
        if (w_mismatch) begin
            o_class.kind = KIND_ERR;
        end else if (!outside_balance(i_float_mv, i_bal_lo, i_bal_hi) && i_pin6_flag) begin
            o_class.kind = KIND_ERR;
        end else if (w_bad_level) begin
            o_class.kind = KIND_ERR;
        end else if (i_float_mv < i_bal_lo) begin
            o_class.to_found = 1'b1;
            if (i_float_mv > MV_MINI_HIGH2) begin
                o_class.kind = KIND_NEW;
            end else if (i_float_mv > MV_MINI_LOW2) begin
                o_class.kind = KIND_MINI;
            end else begin
                o_class.kind = KIND_TACHO;
            end
        end else begin
            // floating reading not below window: needs the pin-5 drive test
            o_class.to_pin5 = 1'b1;
        end
    end

endmodule

>>> rtl/core/opdd_fsm.sv
// ----------------------------------------------------------------------------
// opdd_fsm
// Detection sequencer: state, tick counter, readings and pin modes.
// ----------------------------------------------------------------------------
module opdd_fsm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [opdd_pkg::MV_W-1:0] i_pin5_mv,
    input  logic                      i_pin6_high,
    input  logic                      i_motor_present,
    input  logic                      i_worker_busy,
    input  opdd_pkg::t_cfg            i_cfg,
    output opdd_pkg::t_result         o_result
);
    import opdd_pkg::*;

    logic [2:0]            r_state,  n_state;
    logic [COUNT_BITS-1:0] r_tick,   n_tick;
    logic [1:0]            r_flags,  n_flags;
    logic [MV_W-1:0]       r_float,  n_float;
    logic [MV_W-1:0]       r_low,    n_low;
    logic [2:0]            r_kind,   n_kind;
    logic [1:0]            r_p5,     n_p5;
    logic                  r_p6,     n_p6;
    logic                  w_fl, w_reg, w_unreg;
    logic [1:0]            w_nf;
    t_class                w_class;

    opdd_classify u_classify (
        .i_float_mv  (r_float),
        .i_low_mv    (r_low),
        .i_pin6_flag (r_flags[1]),
        .i_bal_lo    (i_cfg.balance_low_mv),
        .i_bal_hi    (i_cfg.balance_high_mv),
        .o_class     (w_class)
    );

    always_comb begin
        n_state = r_state;
        n_tick  = r_tick;
        n_flags = r_flags;
        n_float = r_float;
        n_low   = r_low;
        n_kind  = r_kind;
        n_p5    = r_p5;
        n_p6    = r_p6;
        w_fl    = 1'b0;
        w_reg   = 1'b0;
        w_unreg = 1'b0;
        w_nf    = {i_pin6_high,
                   outside_balance(i_pin5_mv, i_cfg.balance_low_mv, i_cfg.balance_high_mv)};

        if (i_cfg.restart) begin
            n_state = ST_INIT;
        end else if (i_step && i_cfg.auto_enable) begin
            if (r_tick != CNT_MAX) begin
                n_tick = r_tick + COUNT_BITS'(1);
            end
            case (r_state)
                ST_INIT: begin
                    if (!i_motor_present) begin
                        w_fl    = 1'b1;
                        n_p5    = P5_RELEASED;
                        n_p6    = 1'b0;
                        n_tick  = '0;
                        n_kind  = KIND_NONE;
                        n_state = ST_INIT_SETTLE;
                    end
                end
                ST_INIT_SETTLE: begin
                    if (count_reached(n_tick, i_cfg.settle_ticks)) begin
                        n_tick  = '0;
                        n_state = ST_NO_DEV;
                    end
                end
                ST_NO_DEV: begin
                    // load pattern change restarts the steadiness count
                    if (w_nf != r_flags) begin
                        n_flags = w_nf;
                        n_tick  = '0;
                    end
                    if (n_flags != 2'b00 && count_reached(n_tick, i_cfg.add_ticks)) begin
                        n_float = i_pin5_mv;
                        n_tick  = '0;
                        n_p6    = 1'b1;
                        n_state = ST_PIN6_SETTLE;
                    end
                end
                ST_PIN6_SETTLE: begin
                    if (count_reached(n_tick, i_cfg.settle_ticks)) begin
                        n_low   = i_pin5_mv;
                        n_tick  = '0;
                        n_p6    = 1'b0;
                        n_state = ST_CONNECTED;
                    end
                end
                ST_CONNECTED: begin
                    n_kind = w_class.kind;
                    if (w_class.to_pin5) begin
                        n_kind  = r_kind;
                        n_p5    = P5_HIGH;
                        n_tick  = '0;
                        n_state = ST_PIN5_SETTLE;
                    end else if (w_class.to_found) begin
                        n_state = ST_DEV_FOUND;
                    end else begin
                        n_state = ST_WAIT_DISC;
                    end
                end
                ST_PIN5_SETTLE: begin
                    if (count_reached(n_tick, i_cfg.settle_ticks)) begin
                        n_low   = i_pin5_mv;
                        n_tick  = '0;
                        n_p5    = P5_LOW;
                        if (i_pin5_mv < MV_MINI_LOW1) begin
                            n_kind = KIND_ERR;
                        end else if (i_pin5_mv < MV_MINI_HIGH1) begin
                            n_kind = KIND_MINI;
                        end else begin
                            n_kind = KIND_TACHO;
                        end
                        n_state = ST_DEV_FOUND;
                    end
                end
                ST_DEV_FOUND: begin
                    n_tick = '0;
                    // an error kind parks here until auto mode restarts
                    if (r_kind != KIND_ERR && !i_worker_busy) begin
                        w_reg   = 1'b1;
                        n_state = ST_WAIT_DISC;
                    end
                end
                default: begin
                    if (w_nf[0]) begin
                        n_tick = '0;
                    end
                    if (count_reached(n_tick, i_cfg.remove_ticks) && !i_worker_busy) begin
                        w_unreg = 1'b1;
                        n_state = ST_INIT;
                    end
                end
            endcase
        end

        o_result.link_state       = n_state;
        o_result.detected_type    = n_kind;
        o_result.pin6_drive_low   = n_p6;
        o_result.pin5_drive       = n_p5;
        o_result.float_pulse      = w_fl;
        o_result.register_pulse   = w_reg;
        o_result.unregister_pulse = w_unreg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_tick  <= '0;
            r_flags <= '0;
            r_float <= '0;
            r_low   <= '0;
            r_kind  <= KIND_NONE;
            r_p5    <= P5_RELEASED;
            r_p6    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_flags <= n_flags;
            r_float <= n_float;
            r_low   <= n_low;
            r_kind  <= n_kind;
            r_p5    <= n_p5;
            r_p6    <= n_p6;
        end
    end

endmodule

>>> rtl/core/output_port_device_detector.sv
// ----------------------------------------------------------------------------
// output_port_device_detector
// Poll-tick driven detection sequencer for a motor output port.
// ----------------------------------------------------------------------------
// Each accepted tick beat is captured in an input register, advances the
// eight-state detection sequence when it moves on, and its result beat lands
// in an output register; one tick per clock is sustained while result beats
// are taken, and a stalled result beat holds back new ticks. A result beat
// passes the input register and then the result register.
// Every tick yields exactly one result beat with the state, type, pin drives
// and one-tick float/register/unregister requests. With auto mode off, ticks
// still yield a result but change nothing. Configuration writes take effect at
// once and are expected only while no tick is in flight.
module output_port_device_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [opdd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [opdd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [opdd_pkg::MV_W-1:0]         i_pin5_mv,
    input  logic                              i_pin6_high,
    input  logic                              i_motor_present,
    input  logic                              i_worker_busy,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_link_state,
    output logic [2:0]                        o_detected_type,
    output logic                              o_pin6_drive_low,
    output logic [1:0]                        o_pin5_drive,
    output logic                              o_float_pulse,
    output logic                              o_register_pulse,
    output logic                              o_unregister_pulse
);
    import opdd_pkg::*;

    logic            r_in_valid;
    logic [MV_W-1:0] r_pin5_mv;
    logic            r_pin6_high;
    logic            r_motor;
    logic            r_busy;
    logic            r_out_valid;
    t_result         r_res;
    t_result         w_res;
    t_cfg            w_cfg;
    logic            w_adv;

    // input beat moves on when the result slot is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    opdd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    opdd_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_adv),
        .i_pin5_mv       (r_pin5_mv),
        .i_pin6_high     (r_pin6_high),
        .i_motor_present (r_motor),
        .i_worker_busy   (r_busy),
        .i_cfg           (w_cfg),
        .o_result        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pin5_mv   <= i_pin5_mv;
            r_pin6_high <= i_pin6_high;
            r_motor     <= i_motor_present;
            r_busy      <= i_worker_busy;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_link_state       = r_res.link_state;
    assign o_detected_type    = r_res.detected_type;
    assign o_pin6_drive_low   = r_res.pin6_drive_low;
    assign o_pin5_drive       = r_res.pin5_drive;
    assign o_float_pulse      = r_res.float_pulse;
    assign o_register_pulse   = r_res.register_pulse;
    assign o_unregister_pulse = r_res.unregister_pulse;

endmodule

>>> rtl/core/opdd_checker.sv
// ----------------------------------------------------------------------------
// opdd_checker
// Port-level checks on result beats of the device detector.
// ----------------------------------------------------------------------------
module opdd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_ready,
    input  logic       o_out_valid,
    input  logic [2:0] o_link_state,
    input  logic [2:0] o_detected_type,
    input  logic       o_pin6_drive_low,
    input  logic [1:0] o_pin5_drive,
    input  logic       o_float_pulse,
    input  logic       o_register_pulse,
    input  logic       o_unregister_pulse
);
    import opdd_pkg::*;

    // a float request always leaves the port released and untyped
    a_float_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_float_pulse) |->
            (o_link_state == ST_INIT_SETTLE && o_detected_type == KIND_NONE
             && o_pin5_drive == P5_RELEASED && !o_pin6_drive_low))
        else $error("float beat with pins not released");

    a_reg_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_register_pulse) |->
            (o_link_state == ST_WAIT_DISC && o_detected_type != KIND_ERR
             && o_detected_type != KIND_NONE))
        else $error("register request outside wait-disconnect or with bad type");

    a_unreg_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unregister_pulse) |-> (o_link_state == ST_INIT))
        else $error("unregister request without return to init");

    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_float_pulse, o_register_pulse, o_unregister_pulse}))
        else $error("more than one request in a beat");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_link_state)
                                            && $stable(o_detected_type)))
        else $error("stalled result beat changed");

endmodule

bind output_port_device_detector opdd_checker u_opdd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_ready        (i_out_ready),
    .o_out_valid        (o_out_valid),
    .o_link_state       (o_link_state),
    .o_detected_type    (o_detected_type),
    .o_pin6_drive_low   (o_pin6_drive_low),
    .o_pin5_drive       (o_pin5_drive),
    .o_float_pulse      (o_float_pulse),
    .o_register_pulse   (o_register_pulse),
    .o_unregister_pulse (o_unregister_pulse)
);
